>>> sv/frs_pkg.sv
// Shared types and constants for the flash read retry sequencer.
package frs_pkg;

    // Field widths fixed by the interface.
    localparam int LINE_W    = 16;
    localparam int SPIN_W    = 17;
    localparam int ATT_W     = 3;
    localparam int STAT_W    = 3;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Configuration reset values.
    localparam logic [SPIN_W-1:0] SPIN_LIMIT_RST    = 17'd96000;
    localparam logic [ATT_W-1:0]  ATTEMPT_LIMIT_RST = 3'd3;

    // Register indexes on the configuration port.
    localparam logic REG_SPIN_LIMIT    = 1'b0;
    localparam logic REG_ATTEMPT_LIMIT = 1'b1;

    // Input operation codes.
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    // Result kinds.
    localparam logic KIND_ISSUE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Completion status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_SUCCESS = 3'd0,
        ST_FAIL    = 3'd1,
        ST_NOTSUP  = 3'd2,
        ST_ECC     = 3'd3,
        ST_TIMEOUT = 3'd4
    } cmpl_code_t;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

    // Controller status sample carried by a beat.
    typedef struct packed {
        logic   done;
        logic   fail;
        logic   err;
        logic   ecc;
        words_t words;
    } sample_t;

    // Programmed limits.
    typedef struct packed {
        logic [SPIN_W-1:0] spin_limit;
        logic [ATT_W-1:0]  attempt_limit;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic              kind;
        logic [LINE_W-1:0] start_line;
        cmpl_code_t        status;
        words_t            words;
    } result_t;

    // Engine status seen by the top level.
    typedef struct packed {
        logic busy;
        logic sticky_timeout;
    } eng_status_t;

endpackage

>>> sv/frs_regs.sv
// APB configuration registers for the flash read retry sequencer.
module frs_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [frs_pkg::PADDR_W-1:0]  paddr,
    input  logic [frs_pkg::PDATA_W-1:0]  pwdata,
    output logic [frs_pkg::PDATA_W-1:0]  prdata,
    output frs_pkg::cfg_t                cfg
);
    import frs_pkg::*;

    logic [SPIN_W-1:0] spin_limit_reg;
    logic [ATT_W-1:0]  attempt_limit_reg;
    logic              reg_index;
    logic              wr_en;

    // Registers sit at 4-byte spacing.
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_limit_reg    <= SPIN_LIMIT_RST;
            attempt_limit_reg <= ATTEMPT_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_SPIN_LIMIT:    spin_limit_reg    <= pwdata[SPIN_W-1:0];
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= pwdata[ATT_W-1:0];
                default:           spin_limit_reg    <= spin_limit_reg;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (reg_index)
            REG_SPIN_LIMIT:    prdata = PDATA_W'(spin_limit_reg);
            REG_ATTEMPT_LIMIT: prdata = PDATA_W'(attempt_limit_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.spin_limit    = spin_limit_reg;
    assign cfg.attempt_limit = attempt_limit_reg;

endmodule

>>> sv/frs_engine.sv
// Per-beat decision logic and sequencer state for the flash read retry sequencer.
module frs_engine #(
    parameter int ADDR_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  op,
    input  logic [ADDR_BITS-1:0]  address,
    input  frs_pkg::sample_t      sample,
    input  frs_pkg::cfg_t         cfg,
    output logic                  emit,
    output frs_pkg::result_t      result,
    output frs_pkg::eng_status_t  eng_status
);
    import frs_pkg::*;

    logic              busy_reg, busy_next;
    logic              sticky_reg, sticky_next;
    logic [ATT_W-1:0]  attempt_count_reg, attempt_count_next;
    logic [SPIN_W-1:0] spin_count_reg, spin_count_next;
    logic [LINE_W-1:0] pending_line_reg, pending_line_next;

    logic [ADDR_BITS-1:0] addr_shift;
    logic [LINE_W-1:0]    line_in;
    logic [SPIN_W-1:0]    spin_inc;
    cmpl_code_t           err_code;

    // Line index is the byte address over 16, kept to 16 bits.
    assign addr_shift = address >> 4;
    assign line_in    = LINE_W'(addr_shift);
    assign spin_inc   = spin_count_reg + SPIN_W'(1);

    // Error flags are checked fail first, then err, then ecc.
    always_comb
    begin
        priority if (sample.fail)
            err_code = ST_FAIL;
        else if (sample.err)
            err_code = ST_NOTSUP;
        else if (sample.ecc)
            err_code = ST_ECC;
        else
            err_code = ST_SUCCESS;
    end

    // Decision for the beat in the input register.
    always_comb
    begin
        busy_next          = busy_reg;
        sticky_next        = sticky_reg;
        attempt_count_next = attempt_count_reg;
        spin_count_next    = spin_count_reg;
        pending_line_next  = pending_line_reg;
        emit               = 1'b0;
        result             = '0;

        if (op == OP_REQUEST)
        begin
            if (!busy_reg)
            begin
                emit = 1'b1;
                if (sticky_reg)
                begin
                    result.kind   = KIND_DONE;
                    result.status = ST_TIMEOUT;
                end
                else
                begin
                    pending_line_next  = line_in;
                    busy_next          = 1'b1;
                    attempt_count_next = ATT_W'(1);
                    spin_count_next    = '0;
                    result.kind        = KIND_ISSUE;
                    result.start_line  = line_in;
                end
            end
        end
        else if (busy_reg)
        begin
            if (!sample.done)
            begin
                // Not done yet: count the spin and time out at the limit.
                if (spin_inc >= cfg.spin_limit)
                begin
                    sticky_next        = 1'b1;
                    busy_next          = 1'b0;
                    spin_count_next    = '0;
                    attempt_count_next = '0;
                    emit               = 1'b1;
                    result.kind        = KIND_DONE;
                    result.status      = ST_TIMEOUT;
                end
                else
                begin
                    spin_count_next = spin_inc;
                end
            end
            else if (err_code == ST_SUCCESS)
            begin
                busy_next          = 1'b0;
                spin_count_next    = '0;
                attempt_count_next = '0;
                emit               = 1'b1;
                result.kind        = KIND_DONE;
                result.status      = ST_SUCCESS;
                result.words       = sample.words;
            end
            else if (attempt_count_reg >= cfg.attempt_limit)
            begin
                busy_next          = 1'b0;
                spin_count_next    = '0;
                attempt_count_next = '0;
                emit               = 1'b1;
                result.kind        = KIND_DONE;
                result.status      = err_code;
            end
            else
            begin
                // Retry the same line.
                attempt_count_next = attempt_count_reg + ATT_W'(1);
                spin_count_next    = '0;
                emit               = 1'b1;
                result.kind        = KIND_ISSUE;
                result.start_line  = pending_line_reg;
            end
        end
    end

    // State update when the beat leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            sticky_reg        <= 1'b0;
            attempt_count_reg <= '0;
            spin_count_reg    <= '0;
            pending_line_reg  <= '0;
        end
        else if (step_en)
        begin
            busy_reg          <= busy_next;
            sticky_reg        <= sticky_next;
            attempt_count_reg <= attempt_count_next;
            spin_count_reg    <= spin_count_next;
            pending_line_reg  <= pending_line_next;
        end
    end

    assign eng_status.busy           = busy_reg;
    assign eng_status.sticky_timeout = sticky_reg;

endmodule

>>> sv/flash_read_retry_sequencer.sv
// Flash read retry sequencer: input register, decision engine and result register.
// A beat accepted into the input register has its result loaded into the result register
// when the beat moves on, and that register drives out_valid.
// Throughput: one beat per cycle while the input side does not stall; the input register refills while a result waits.
// The input side stalls only when a beat that makes a result meets a full result register while out_ready is low.
// Reset (rst_n low, asynchronous) clears the state and loads spin_limit 96000, attempt_limit 3.
module flash_read_retry_sequencer #(
    parameter int ADDR_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [frs_pkg::PADDR_W-1:0]  paddr,
    input  logic [frs_pkg::PDATA_W-1:0]  pwdata,
    output logic [frs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [ADDR_BITS-1:0]         address,
    input  logic                         flag_done,
    input  logic                         flag_fail,
    input  logic                         flag_err,
    input  logic                         flag_ecc,
    input  logic [frs_pkg::WORD_W-1:0]   rd_word0,
    input  logic [frs_pkg::WORD_W-1:0]   rd_word1,
    input  logic [frs_pkg::WORD_W-1:0]   rd_word2,
    input  logic [frs_pkg::WORD_W-1:0]   rd_word3,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [frs_pkg::LINE_W-1:0]   start_line,
    output logic [frs_pkg::STAT_W-1:0]   status,
    output logic [frs_pkg::WORD_W-1:0]   out_word0,
    output logic [frs_pkg::WORD_W-1:0]   out_word1,
    output logic [frs_pkg::WORD_W-1:0]   out_word2,
    output logic [frs_pkg::WORD_W-1:0]   out_word3
);
    import frs_pkg::*;

    cfg_t        cfg;
    eng_status_t eng_status;
    result_t     eng_result;
    logic        eng_emit;

    logic                 in_valid_reg;
    logic                 op_reg;
    logic [ADDR_BITS-1:0] address_reg;
    sample_t              sample_reg;
    logic                 out_valid_reg;
    result_t              result_reg;
    logic                 in_fire;
    logic                 advance;

    assign pready = 1'b1;

    frs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // A held beat moves on unless it makes a result and the result register is blocked.
    assign advance  = in_valid_reg && (!eng_emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_fire)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg                <= op;
            address_reg           <= address;
            sample_reg.done       <= flag_done;
            sample_reg.fail       <= flag_fail;
            sample_reg.err        <= flag_err;
            sample_reg.ecc        <= flag_ecc;
            sample_reg.words[0]   <= rd_word0;
            sample_reg.words[1]   <= rd_word1;
            sample_reg.words[2]   <= rd_word2;
            sample_reg.words[3]   <= rd_word3;
        end
    end

    frs_engine #(
        .ADDR_BITS (ADDR_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .op         (op_reg),
        .address    (address_reg),
        .sample     (sample_reg),
        .cfg        (cfg),
        .emit       (eng_emit),
        .result     (eng_result),
        .eng_status (eng_status)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && eng_emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && eng_emit)
            result_reg <= eng_result;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = result_reg.kind;
    assign start_line = result_reg.start_line;
    assign status     = STAT_W'(result_reg.status);
    assign out_word0  = result_reg.words[0];
    assign out_word1  = result_reg.words[1];
    assign out_word2  = result_reg.words[2];
    assign out_word3  = result_reg.words[3];

    // The sticky timeout only clears through reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.sticky_timeout |=> eng_status.sticky_timeout)
        else $error("sticky timeout cleared outside reset");

    // An issued command leaves the sequencer busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && eng_emit && (eng_result.kind == KIND_ISSUE) |=> eng_status.busy)
        else $error("issued command without busy state");

    // A held beat stalls only behind a blocked result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> eng_emit && out_valid_reg && !out_ready)
        else $error("input beat stalled without a blocked result");

    // A loaded result is offered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && eng_emit |=> out_valid_reg)
        else $error("result beat lost");

endmodule

>>> dv/tb_flash_read_retry_sequencer.sv
// Self-checking testbench for the flash read retry sequencer, with its own model of the read flow.
module tb_flash_read_retry_sequencer;
    import frs_pkg::*;

    localparam int ADDR_W    = 20;
    localparam int SETTLE    = 4;
    localparam int RUN_LIMIT = 2000000;
    localparam int DIR_N     = 24;

    // One input beat as the sender sees it.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        sample_t           smp;
    } beat_t;

    // One directed row: flags are {done, fail, err, ecc}.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        flags;
        words_t            words;
        logic              typed;
        result_t           want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  op = 1'b0;
    logic [ADDR_W-1:0]     address = '0;
    logic                  flag_done = 1'b0;
    logic                  flag_fail = 1'b0;
    logic                  flag_err = 1'b0;
    logic                  flag_ecc = 1'b0;
    logic [WORD_W-1:0]     rd_word0 = '0;
    logic [WORD_W-1:0]     rd_word1 = '0;
    logic [WORD_W-1:0]     rd_word2 = '0;
    logic [WORD_W-1:0]     rd_word3 = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  kind;
    logic [LINE_W-1:0]     start_line;
    logic [STAT_W-1:0]     status;
    logic [WORD_W-1:0]     out_word0;
    logic [WORD_W-1:0]     out_word1;
    logic [WORD_W-1:0]     out_word2;
    logic [WORD_W-1:0]     out_word3;

    // Model of the read flow and the programmed limits.
    logic                  flow_busy = 1'b0;
    logic [ATT_W-1:0]      flow_attempts = '0;
    logic [SPIN_W-1:0]     flow_spins = '0;
    logic                  flow_sticky = 1'b0;
    logic [LINE_W-1:0]     flow_line = '0;
    logic [SPIN_W-1:0]     lim_spin = SPIN_LIMIT_RST;
    logic [ATT_W-1:0]      lim_attempts = ATTEMPT_LIMIT_RST;

    result_t               read_flow_q[$];
    int                    fail_count = 0;
    int                    snd_idle_pct = 22;
    int                    rcv_idle_pct = 48;

    // Directed rows, run right after reset with the reset limits.
    dir_row_t dir_rows [DIR_N] = '{
        // A sample with no read outstanding is dropped.
        '{OP_SAMPLE, 20'h00000, 4'b1000, '0, 1'b0, '0},
        '{OP_REQUEST, 20'h00000, 4'b0000, '0, 1'b1, '{KIND_ISSUE, 16'h0000, ST_SUCCESS, '0}},
        // A request while busy is dropped.
        '{OP_REQUEST, 20'hFFFFF, 4'b0000, '0, 1'b0, '0},
        // Error flags without done only count a spin.
        '{OP_SAMPLE, 20'h00000, 4'b0111, '1, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1000, '1, 1'b1, '{KIND_DONE, 16'h0000, ST_SUCCESS, '1}},
        '{OP_REQUEST, 20'hFFFFF, 4'b0000, '0, 1'b1, '{KIND_ISSUE, 16'hFFFF, ST_SUCCESS, '0}},
        // Retries reissue the same line until the attempt limit is reached.
        '{OP_SAMPLE, 20'h00000, 4'b1111, '1, 1'b1, '{KIND_ISSUE, 16'hFFFF, ST_SUCCESS, '0}},
        '{OP_SAMPLE, 20'h00000, 4'b1011, '1, 1'b1, '{KIND_ISSUE, 16'hFFFF, ST_SUCCESS, '0}},
        '{OP_SAMPLE, 20'h00000, 4'b1001, '1, 1'b1, '{KIND_DONE, 16'h0000, ST_ECC, '0}},
        '{OP_REQUEST, 20'h12345, 4'b0000, '0, 1'b1, '{KIND_ISSUE, 16'h1234, ST_SUCCESS, '0}},
        '{OP_SAMPLE, 20'h00000, 4'b1100, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1110, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1101, '1, 1'b1, '{KIND_DONE, 16'h0000, ST_FAIL, '0}},
        '{OP_REQUEST, 20'hA5A5F, 4'b0000, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b0000, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1010, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b0001, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1010, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1011, '1, 1'b1, '{KIND_DONE, 16'h0000, ST_NOTSUP, '0}},
        '{OP_REQUEST, 20'h5A5A0, 4'b0000, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1000, '0, 1'b1, '{KIND_DONE, 16'h0000, ST_SUCCESS, '0}},
        '{OP_REQUEST, 20'h0000F, 4'b0000, '0, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b1000,
          {32'hF0F0F0F0, 32'h0F0F0F0F, 32'h5A5A5A5A, 32'hA5A5A5A5}, 1'b0, '0},
        '{OP_SAMPLE, 20'h00000, 4'b0100, '0, 1'b0, '0}
    };

    flash_read_retry_sequencer #(
        .ADDR_BITS(ADDR_W)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .address    (address),
        .flag_done  (flag_done),
        .flag_fail  (flag_fail),
        .flag_err   (flag_err),
        .flag_ecc   (flag_ecc),
        .rd_word0   (rd_word0),
        .rd_word1   (rd_word1),
        .rd_word2   (rd_word2),
        .rd_word3   (rd_word3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .start_line (start_line),
        .status     (status),
        .out_word0  (out_word0),
        .out_word1  (out_word1),
        .out_word2  (out_word2),
        .out_word3  (out_word3)
    );

    always #5 clk = ~clk;

    // Advance the read flow by one accepted beat; returns 1 when a result beat follows.
    function automatic bit read_flow_step(input beat_t b, output result_t r);
        cmpl_code_t code;
        r = '0;
        if (b.op == OP_REQUEST) begin
            if (flow_busy)
                return 1'b0;
            if (flow_sticky) begin
                r.kind   = KIND_DONE;
                r.status = ST_TIMEOUT;
                return 1'b1;
            end
            flow_line     = LINE_W'(b.addr >> 4);
            flow_busy     = 1'b1;
            flow_attempts = ATT_W'(1);
            flow_spins    = '0;
            r.kind        = KIND_ISSUE;
            r.start_line  = flow_line;
            return 1'b1;
        end
        if (!flow_busy)
            return 1'b0;

        // Not done yet: count a spin and give up at the limit for good.
        if (!b.smp.done) begin
            flow_spins = flow_spins + 1'b1;
            if (flow_spins >= lim_spin) begin
                flow_sticky   = 1'b1;
                flow_busy     = 1'b0;
                flow_spins    = '0;
                flow_attempts = '0;
                r.kind        = KIND_DONE;
                r.status      = ST_TIMEOUT;
                return 1'b1;
            end
            return 1'b0;
        end

        // Done: fail wins over err, err over ecc.
        if (b.smp.fail)
            code = ST_FAIL;
        else if (b.smp.err)
            code = ST_NOTSUP;
        else if (b.smp.ecc)
            code = ST_ECC;
        else
            code = ST_SUCCESS;

        if (code == ST_SUCCESS || flow_attempts >= lim_attempts) begin
            flow_busy     = 1'b0;
            flow_spins    = '0;
            flow_attempts = '0;
            r.kind        = KIND_DONE;
            r.status      = code;
            if (code == ST_SUCCESS)
                r.words = b.smp.words;
            return 1'b1;
        end

        // Retry the same line with a fresh spin count.
        flow_attempts = flow_attempts + 1'b1;
        flow_spins    = '0;
        r.kind        = KIND_ISSUE;
        r.start_line  = flow_line;
        return 1'b1;
    endfunction

    // Mostly well-formed read flows with random content, plus dropped beats as noise.
    function automatic beat_t next_beat(input bit allow_timeout);
        beat_t b;
        b.addr      = ADDR_W'($urandom);
        b.smp.words = {$urandom, $urandom, $urandom, $urandom};
        b.smp.done  = 1'($urandom_range(0, 1));
        b.smp.fail  = 1'($urandom_range(0, 1));
        b.smp.err   = 1'($urandom_range(0, 1));
        b.smp.ecc   = 1'($urandom_range(0, 1));
        if (!flow_busy) begin
            b.op = ($urandom_range(0, 99) < 88) ? OP_REQUEST : OP_SAMPLE;
        end
        else if ($urandom_range(0, 99) < 8) begin
            b.op = OP_REQUEST;
        end
        else begin
            b.op       = OP_SAMPLE;
            b.smp.done = ($urandom_range(0, 99) >= 35);
            if (!allow_timeout && int'(flow_spins) + 1 >= int'(lim_spin))
                b.smp.done = 1'b1;
            b.smp.fail = ($urandom_range(0, 99) < 25);
            b.smp.err  = ($urandom_range(0, 99) < 25);
            b.smp.ecc  = ($urandom_range(0, 99) < 25);
        end
        return b;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Present one beat after an optional gap and hold it until it is accepted.
    task automatic drive_beat(input beat_t b, input bit typed, input result_t want);
        result_t r;
        bit      has_res;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        in_valid  <= 1'b1;
        op        <= b.op;
        address   <= b.addr;
        flag_done <= b.smp.done;
        flag_fail <= b.smp.fail;
        flag_err  <= b.smp.err;
        flag_ecc  <= b.smp.ecc;
        rd_word0  <= b.smp.words[0];
        rd_word1  <= b.smp.words[1];
        rd_word2  <= b.smp.words[2];
        rd_word3  <= b.smp.words[3];
        do @(posedge clk); while (!in_ready);
        has_res = read_flow_step(b, r);
        if (typed)
            read_flow_q.push_back(want);
        else if (has_res)
            read_flow_q.push_back(r);
    endtask

    // Stop sending and wait until every predicted result beat has come back.
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (read_flow_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Read a register back and compare; leaves the bus idle after the transfer.
    task automatic check_reg(input logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field(idx == REG_SPIN_LIMIT ? "spin_limit readback" : "attempt_limit readback",
                    idx == REG_SPIN_LIMIT ? 32'(lim_spin) : 32'(lim_attempts), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_SPIN_LIMIT)
            lim_spin = value[SPIN_W-1:0];
        else
            lim_attempts = value[ATT_W-1:0];
        check_reg(idx);
    endtask

    // One setting of the limits and idle rates, with a full drain midway and at the end.
    task automatic run_phase(input int spin, input int att, input int snd, input int rcv,
                             input int n, input bit allow_timeout);
        beat_t b;
        write_reg(REG_SPIN_LIMIT, 32'(spin));
        write_reg(REG_ATTEMPT_LIMIT, 32'(att));
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2)
                drain_results(0);
            b = next_beat(allow_timeout);
            drive_beat(b, 1'b0, '0);
        end
        // Close out a read still in flight so the next setting starts idle.
        while (flow_busy) begin
            b          = next_beat(1'b0);
            b.op       = OP_SAMPLE;
            b.smp.done = 1'b1;
            b.smp.fail = 1'b0;
            b.smp.err  = 1'b0;
            b.smp.ecc  = 1'b0;
            drive_beat(b, 1'b0, '0);
        end
        drain_results(SETTLE);
    endtask

    // Receiver stalls at random.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge clk) begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (read_flow_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result beat with nothing predicted, kind %0d status %0d",
                             $time, kind, status);
            end
            else begin
                want = read_flow_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("start_line", 32'(want.start_line), 32'(start_line));
                check_field("status", 32'(want.status), 32'(status));
                check_field("out_word0", want.words[0], out_word0);
                check_field("out_word1", want.words[1], out_word1);
                check_field("out_word2", want.words[2], out_word2);
                check_field("out_word3", want.words[3], out_word3);
            end
        end
    end

    initial begin : stimulus
        beat_t row_b;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reg(REG_SPIN_LIMIT);
        check_reg(REG_ATTEMPT_LIMIT);

        // Directed rows under the reset limits.
        for (int i = 0; i < DIR_N; i++) begin
            row_b.op    = dir_rows[i].op;
            row_b.addr  = dir_rows[i].addr;
            row_b.smp   = '{dir_rows[i].flags[3], dir_rows[i].flags[2], dir_rows[i].flags[1],
                            dir_rows[i].flags[0], dir_rows[i].words};
            drive_beat(row_b, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_results(SETTLE);

        // Random flows over a sweep of limits; a zero attempt limit acts as one.
        run_phase(131071, 7, 22, 48, 250, 1'b0);
        run_phase(1, 1, 22, 48, 150, 1'b0);
        run_phase(40, 0, 48, 22, 150, 1'b0);
        run_phase(3, 2, 48, 22, 250, 1'b0);
        run_phase(96000, 5, 0, 0, 250, 1'b0);
        // A zero spin limit times out on the first sample without done; the timeout sticks.
        run_phase(0, 3, 0, 0, 150, 1'b1);

        drain_results(8);
        if (fail_count == 0 && read_flow_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
